>>> rtl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // A cell holds the character in the low byte and the attribute in the high byte.
  localparam int CELL_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_IN_BUF = 1'b1;
  localparam logic [7:0] ATTR_RESET = 8'h07;

  // Special characters.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_MARK    = 8'h5F;
  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] MARK_ATTR  = 8'h00;
  localparam int TAB_STOP = 8;
  localparam int TAB_W    = $clog2(TAB_STOP);

  // Request codes.
  typedef enum logic [2:0] {
    REQ_PUT   = 3'd0,
    REQ_SET   = 3'd1,
    REQ_CLEAR = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_READ  = 3'd4
  } req_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_BLANK,
    ST_MOVE,
    ST_SEEK,
    ST_MARK,
    ST_READ,
    ST_DONE
  } state_t;

  // One result item.
  typedef struct packed {
    logic [6:0] cursor_column;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       did_scroll;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/tcw_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel.
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] char_code;
  logic [6:0] column;
  logic [4:0] row;

  modport source (output valid, output req_type, output char_code, output column,
                  output row, input ready);
  modport sink (input valid, input req_type, input char_code, input column,
                input row, output ready);
endinterface

// Result channel.
interface tcw_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cursor_column;
  logic [4:0] cursor_row;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;
  logic       did_scroll;

  modport source (output valid, output cursor_column, output cursor_row,
                  output cell_char, output cell_attr, output did_scroll, input ready);
  modport sink (input valid, input cursor_column, input cursor_row,
                input cell_char, input cell_attr, input did_scroll, output ready);
endinterface

`default_nettype wire

>>> rtl/tcw_cell_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [tcw_pkg::CELL_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output logic      [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  // One write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/tcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELLS = COLUMNS * ROWS,
  localparam int AW    = $clog2(CELLS)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Request side.
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [2:0]                 req_type,
  input  wire logic [7:0]                 char_code,
  input  wire logic [6:0]                 column,
  input  wire logic [4:0]                 row,
  // Configuration.
  input  wire logic [7:0]                 dflt_attr,
  input  wire logic                       cursor_in_buf,
  // Result side.
  input  wire logic                       res_free,
  output logic                            res_load,
  output tcw_pkg::res_t                   res,
  // Screen store.
  output logic                            ram_we,
  output logic [AW-1:0]                   ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0]      ram_wdata,
  output logic [AW-1:0]                   ram_raddr,
  input  wire logic [tcw_pkg::CELL_W-1:0] ram_rdata
);
  import tcw_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  state_t            state_r, state_nxt;
  logic [AW:0]       idx_r, idx_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic              seek_vld_r, seek_vld_nxt;
  logic [2:0]        req_r, req_nxt;
  logic [7:0]        ch_r, ch_nxt;
  logic [6:0]        colin_r, colin_nxt;
  logic [4:0]        rowin_r, rowin_nxt;
  logic              scrolled_r, scrolled_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;

  logic              onscreen;
  logic [CW-1:0]     clamp_col;
  logic [RW-1:0]     clamp_row;
  logic [AW-1:0]     lin;
  logic [CW:0]       step;
  logic [CW:0]       col_sum;
  logic              wrap;
  logic [CW-1:0]     new_col;
  logic [AW-1:0]     pos_adv;
  logic              put_scroll;
  logic              is_glyph;
  logic [CELL_W-1:0] blank_cell;
  logic [CELL_W-1:0] mark_cell;

  assign blank_cell = {dflt_attr, CH_BLANK};
  assign mark_cell  = {MARK_ATTR, CH_MARK};

  // Position decode for set cursor, write at and read.
  always_comb begin
    onscreen  = (32'(colin_r) < COLUMNS) && (32'(rowin_r) < ROWS);
    clamp_col = (32'(colin_r) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(colin_r);
    clamp_row = (32'(rowin_r) >= ROWS) ? RW'(ROWS - 1) : RW'(rowin_r);
    lin       = AW'(32'(clamp_row) * COLUMNS + 32'(clamp_col));
  end

  // Cursor advance: one step value serves glyph, tab and newline.
  always_comb begin
    is_glyph = (ch_r != CH_NEWLINE) && (ch_r != CH_TAB);
    if (ch_r == CH_NEWLINE) begin
      step = (CW+1)'(COLUMNS - 32'(col_r));
    end else if (ch_r == CH_TAB) begin
      step = (CW+1)'(TAB_STOP - 32'(pos_r[TAB_W-1:0]));
    end else begin
      step = (CW+1)'(1);
    end
    col_sum    = {1'b0, col_r} + step;
    wrap       = (32'(col_sum) >= COLUMNS);
    new_col    = wrap ? CW'(col_sum - (CW+1)'(COLUMNS)) : CW'(col_sum);
    pos_adv    = AW'({1'b0, pos_r} + (AW+1)'(step));
    put_scroll = wrap && (32'(row_r) == ROWS - 1);
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      idx_r      <= '0;
      pos_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
      seek_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      pos_r      <= pos_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      seek_vld_r <= seek_vld_nxt;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    ch_r       <= ch_nxt;
    colin_r    <= colin_nxt;
    rowin_r    <= rowin_nxt;
    scrolled_r <= scrolled_nxt;
    cell_r     <= cell_nxt;
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    seek_vld_nxt = seek_vld_r;
    req_nxt      = req_r;
    ch_nxt       = ch_r;
    colin_nxt    = colin_r;
    rowin_nxt    = rowin_r;
    scrolled_nxt = scrolled_r;
    cell_nxt     = cell_r;
    in_ready     = 1'b0;
    res_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = blank_cell;
    ram_raddr    = idx_r[AW-1:0];

    case (state_r)
      // Zero the store after reset.
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = '0;
        if (idx_r == (AW+1)'(CELLS - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = req_type;
          ch_nxt    = char_code;
          colin_nxt = column;
          rowin_nxt = row;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        scrolled_nxt = 1'b0;
        cell_nxt     = '0;
        case (req_r)
          REQ_PUT: begin
            if (is_glyph) begin
              ram_we    = 1'b1;
              ram_waddr = pos_r;
              ram_wdata = {dflt_attr, ch_r};
            end
            if (put_scroll) begin
              pos_nxt      = AW'(CELLS - COLUMNS);
              col_nxt      = '0;
              row_nxt      = RW'(ROWS - 1);
              scrolled_nxt = 1'b1;
              idx_nxt      = '0;
              state_nxt    = ST_SCROLL;
            end else begin
              pos_nxt   = pos_adv;
              col_nxt   = new_col;
              row_nxt   = wrap ? RW'(row_r + 1'b1) : row_r;
              state_nxt = ST_MOVE;
            end
          end
          REQ_SET: begin
            pos_nxt   = lin;
            col_nxt   = clamp_col;
            row_nxt   = clamp_row;
            state_nxt = ST_MOVE;
          end
          REQ_CLEAR: begin
            idx_nxt   = '0;
            state_nxt = ST_BLANK;
          end
          REQ_WRITE: begin
            ram_we    = onscreen;
            ram_waddr = lin;
            ram_wdata = {dflt_attr, ch_r};
            state_nxt = ST_DONE;
          end
          REQ_READ: begin
            ram_raddr = lin;
            state_nxt = ST_READ;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      // Copy each cell from one row below; each cell is written in the cycle after its read.
      ST_SCROLL: begin
        ram_raddr = AW'(idx_r + (AW+1)'(COLUMNS));
        if (idx_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(idx_r - 1'b1);
          ram_wdata = ram_rdata;
        end
        if (idx_r == (AW+1)'(CELLS - COLUMNS)) begin
          state_nxt = ST_BLANK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Blank from the index to the end of the store.
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = blank_cell;
        if (idx_r == (AW+1)'(CELLS - 1)) begin
          if (req_r == REQ_CLEAR) begin
            pos_nxt   = '0;
            col_nxt   = '0;
            row_nxt   = '0;
            state_nxt = cursor_in_buf ? ST_MARK : ST_DONE;
          end else begin
            state_nxt = ST_MOVE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_MOVE: begin
        idx_nxt      = '0;
        seek_vld_nxt = 1'b0;
        state_nxt    = cursor_in_buf ? ST_SEEK : ST_DONE;
      end

      // Look for the lowest old cursor mark, one cell a cycle.
      ST_SEEK: begin
        ram_raddr    = idx_r[AW-1:0];
        seek_vld_nxt = 1'b1;
        if (seek_vld_r && (ram_rdata == mark_cell)) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(idx_r - 1'b1);
          ram_wdata = blank_cell;
          state_nxt = ST_MARK;
        end else if (idx_r == (AW+1)'(CELLS)) begin
          state_nxt = ST_MARK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = mark_cell;
        state_nxt = ST_DONE;
      end

      ST_READ: begin
        cell_nxt  = onscreen ? ram_rdata : '0;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        res_load = res_free;
        if (res_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result fields.
  always_comb begin
    res.cursor_column = 7'(col_r);
    res.cursor_row    = 5'(row_r);
    res.cell_char     = cell_r[7:0];
    res.cell_attr     = cell_r[15:8];
    res.did_scroll    = scrolled_r;
  end

endmodule

`default_nettype wire

>>> rtl/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// Character-cell console engine over a ROWS x COLUMNS store of 16-bit cells.
// Requests arrive on in_req (valid/ready); each one yields exactly one
// result on out_res (valid/ready) holding the cursor after the request, the
// cell read, and a scroll flag. cfg_we/cfg_index/cfg_wdata write the default
// attribute (index 0) and the buffer-cursor enable (index 1).
// One request is worked at a time, and in_req.ready is high only while the
// sequencer is idle. A scroll adds a copy of the rows and blanking of the
// last row, and clear blanks the whole store. With the buffer cursor on, each
// cursor move by put or set adds a search of the store, one cell per cycle,
// then draws the mark. The store has a single read and a single write port.
// After reset the store is zeroed, during which no request is taken. A
// result waits in the output register while the receiver stalls; the next
// request is still taken, and its result waits until the register frees up.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  tcw_in_if.sink                                in_req,
  tcw_out_if.source                             out_res
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [7:0]        attr_r, attr_nxt;
  logic              cib_r, cib_nxt;
  logic              out_vld_r, out_vld_nxt;
  res_t              out_res_r, out_res_nxt;
  logic              res_free;
  logic              res_load;
  res_t              res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Configuration registers.
  always_comb begin
    attr_nxt = attr_r;
    cib_nxt  = cib_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DEFAULT_ATTR:  attr_nxt = cfg_wdata[7:0];
        CFG_CURSOR_IN_BUF: cib_nxt  = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
      cib_r  <= 1'b0;
    end else begin
      attr_r <= attr_nxt;
      cib_r  <= cib_nxt;
    end
  end

  // Output register between the sequencer and the receiver.
  assign res_free = !out_vld_r || out_res.ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (res_load) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = res;
    end else if (out_res.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_res.valid         = out_vld_r;
  assign out_res.cursor_column = out_res_r.cursor_column;
  assign out_res.cursor_row    = out_res_r.cursor_row;
  assign out_res.cell_char     = out_res_r.cell_char;
  assign out_res.cell_attr     = out_res_r.cell_attr;
  assign out_res.did_scroll    = out_res_r.did_scroll;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_req.valid),
    .in_ready      (in_req.ready),
    .req_type      (in_req.req_type),
    .char_code     (in_req.char_code),
    .column        (in_req.column),
    .row           (in_req.row),
    .dflt_attr     (attr_r),
    .cursor_in_buf (cib_r),
    .res_free      (res_free),
    .res_load      (res_load),
    .res           (res),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  tcw_cell_ram #(
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

>>> rtl/tcw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] cursor_column,
  input wire logic [4:0] cursor_row,
  input wire logic [7:0] cell_char,
  input wire logic [7:0] cell_attr,
  input wire logic       did_scroll
);

  // The store is being zeroed right after reset, so no request or result.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("request or result seen right after reset");

  // The engine is busy in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is still in work");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cursor_column)
      && $stable(cursor_row) && $stable(cell_char) && $stable(cell_attr)
      && $stable(did_scroll))
    else $error("stalled result changed");

  // The reported cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(cursor_column) < COLUMNS) && (32'(cursor_row) < ROWS))
    else $error("cursor off screen");

  // Only a read returns cell data, and only put char scrolls.
  a_scroll_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && did_scroll |-> (cell_char == 8'h00) && (cell_attr == 8'h00))
    else $error("scroll reported together with cell data");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_req.valid),
  .in_ready      (in_req.ready),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .cursor_column (out_res.cursor_column),
  .cursor_row    (out_res.cursor_row),
  .cell_char     (out_res.cell_char),
  .cell_attr     (out_res.cell_attr),
  .did_scroll    (out_res.did_scroll)
);

`default_nettype wire
